/* design/dbs_pkg.sv */
`default_nettype none
package dbs_pkg;

    // Port table geometry
    localparam int PORT_COUNT = 16;
    localparam int BASE_COUNT = 16;
    localparam int BASE_W     = $clog2(BASE_COUNT);
    localparam int IDX_W      = $clog2(PORT_COUNT);
    localparam int STEP_W     = $clog2(IDX_W);
    localparam int SENT_W     = $clog2(2 * PORT_COUNT + 1);

    localparam logic [SENT_W-1:0] SENT_LIMIT = SENT_W'(2 * PORT_COUNT);

    // Period arithmetic, milliseconds
    localparam logic [19:0] INIT_PERIOD_MS   = 20'd100;
    localparam logic [19:0] MIN_PERIOD_MS    = 20'd100;
    localparam logic [19:0] MAX_PERIOD_LIMIT = 20'd1000000;
    localparam logic [19:0] MAX_PERIOD_RESET = 20'd4000;
    localparam logic [6:0]  PEER_PERIOD_MS   = 7'd100;

    // Register map, index is paddr[4:2]
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_OWN_PORT   = 3'd0;
    localparam logic [2:0] REG_HUB_ACTIVE = 3'd1;
    localparam logic [2:0] REG_LITE       = 3'd2;
    localparam logic [2:0] REG_NETWORK    = 3'd3;
    localparam logic [2:0] REG_MAX_PERIOD = 3'd4;

    localparam logic [4:0] OWN_PORT_NONE = 5'h1f;

    // Request commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_FAIL = 1'b1;

    localparam logic [15:0] BASE_PORTS [BASE_COUNT] = '{
        16'd64541, 16'd60238, 16'd57143, 16'd55764,
        16'd56975, 16'd62711, 16'd57571, 16'd53472,
        16'd51779, 16'd63714, 16'd53304, 16'd61696,
        16'd50665, 16'd49404, 16'd64828, 16'd54859
    };

    typedef struct packed {
        logic       cmd;
        logic [3:0] failed_port;
        logic [9:0] peer_count;
    } t_request;

    typedef struct packed {
        logic [3:0]  port_index;
        logic [15:0] port_number;
        logic        send_local;
        logic        send_remote;
        logic [19:0] next_delay_ms;
    } t_result;

    typedef struct packed {
        logic [4:0]  own_port_index;
        logic        hub_active;
        logic        lite_enabled;
        logic        network_present;
        logic [19:0] max_period_ms;
    } t_cfg;

    typedef struct packed {
        logic clear_fail;
        logic start;
        logic prep;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_fail;
        logic tick_ok;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    // Table entries beyond the base list repeat it
    function automatic logic [15:0] port_of(input logic [IDX_W-1:0] idx);
        return BASE_PORTS[BASE_W'(idx % BASE_COUNT)];
    endfunction

endpackage
`default_nettype wire

/* design/discovery_beacon_scheduler.sv */
// A tick request's result is registered after a preparation step, four radix-2
// remainder steps and a commit, which waits while the output register is busy.
// No new request is accepted until the tick is committed; failure reports and
// dropped ticks are taken in the idle state, which they do not leave.
// Reset: synchronous, active low; clears control, scheduler state and registers.
`default_nettype none
module discovery_beacon_scheduler (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire dbs_pkg::t_request          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output dbs_pkg::t_result                o_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dbs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import dbs_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req       (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* design/dbs_regs.sv */
`default_nettype none
module dbs_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dbs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output dbs_pkg::t_cfg                   o_cfg
);
    import dbs_pkg::*;

    t_cfg        r_cfg;
    logic        w_wr;
    logic [2:0]  w_reg;
    logic [19:0] w_period;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[4:2];

    // Clamp the maximum period into its legal range
    always_comb begin
        w_period = pwdata[19:0];
        if (w_period < MIN_PERIOD_MS) begin
            w_period = MIN_PERIOD_MS;
        end else if (w_period > MAX_PERIOD_LIMIT) begin
            w_period = MAX_PERIOD_LIMIT;
        end
    end

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_port_index  <= OWN_PORT_NONE;
            r_cfg.hub_active      <= 1'b0;
            r_cfg.lite_enabled    <= 1'b0;
            r_cfg.network_present <= 1'b0;
            r_cfg.max_period_ms   <= MAX_PERIOD_RESET;
        end else if (w_wr) begin
            case (w_reg)
                REG_OWN_PORT:   r_cfg.own_port_index  <= pwdata[4:0];
                REG_HUB_ACTIVE: r_cfg.hub_active      <= pwdata[0];
                REG_LITE:       r_cfg.lite_enabled    <= pwdata[0];
                REG_NETWORK:    r_cfg.network_present <= pwdata[0];
                REG_MAX_PERIOD: r_cfg.max_period_ms   <= w_period;
                default: begin
                end
            endcase
        end
    end

    // Read back, own port sign-extended
    always_comb begin
        case (w_reg)
            REG_OWN_PORT:   prdata = {{27{r_cfg.own_port_index[4]}}, r_cfg.own_port_index};
            REG_HUB_ACTIVE: prdata = {31'd0, r_cfg.hub_active};
            REG_LITE:       prdata = {31'd0, r_cfg.lite_enabled};
            REG_NETWORK:    prdata = {31'd0, r_cfg.network_present};
            REG_MAX_PERIOD: prdata = {12'd0, r_cfg.max_period_ms};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* design/dbs_ctrl.sv */
`default_nettype none
module dbs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire dbs_pkg::t_dp_sts i_sts,
    output dbs_pkg::t_dp_cmd      o_cmd
);
    import dbs_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one request at a time
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_sts.is_fail) begin
                        o_cmd.clear_fail = 1'b1;
                    end else if (i_sts.tick_ok) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("result committed while output register busy");

    a_start_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_PREP) && o_in_stall)
        else $error("tick start did not enter preparation");

endmodule
`default_nettype wire

/* design/dbs_dp.sv */
`default_nettype none
module dbs_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dbs_pkg::t_cfg     i_cfg,
    input  wire dbs_pkg::t_request i_req,
    input  wire dbs_pkg::t_dp_cmd  i_cmd,
    output dbs_pkg::t_dp_sts       o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output dbs_pkg::t_result       o_out_data
);
    import dbs_pkg::*;

    // Persistent scheduler state
    logic [IDX_W-1:0]      r_cur;
    logic [SENT_W-1:0]     r_sent;
    logic [19:0]           r_period;
    logic [PORT_COUNT-1:0] r_remote_en;

    // Per-tick working registers
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W:0]    r_div;
    logic [IDX_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_use_mod;
    logic [16:0]       r_peer_ms;
    logic [19:0]       r_ceil;
    logic [20:0]       r_grow;

    logic              r_out_valid;
    t_result           r_out;

    logic [IDX_W:0]    w_rem_sh;
    logic [IDX_W:0]    w_rem_sub;
    logic [23:0]       w_times9;
    logic [IDX_W-1:0]  w_fin_idx;
    logic [19:0]       w_new_period;
    logic [IDX_W-1:0]  w_own;

    assign w_own = i_cfg.own_port_index[IDX_W-1:0];

    // Status toward the controller
    assign o_sts.is_fail  = (i_req.cmd == CMD_FAIL);
    assign o_sts.tick_ok  = (i_req.cmd == CMD_TICK) && !i_cfg.hub_active
                            && !i_cfg.own_port_index[4];
    assign o_sts.div_last = (r_step == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // One restoring-division bit per step
    assign w_rem_sh  = {r_rem, r_idx[r_step]};
    assign w_rem_sub = w_rem_sh - r_div;

    // Grow by nine eighths
    assign w_times9 = {4'd0, r_period} + {1'b0, r_period, 3'b000};

    assign w_fin_idx    = r_use_mod ? r_rem : r_idx;
    assign w_new_period = (r_grow > {1'b0, r_ceil}) ? r_ceil : r_grow[19:0];

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx     <= r_cur + 1'b1;
            r_div     <= {1'b0, w_own} + 1'b1;
            r_rem     <= '0;
            r_step    <= STEP_W'(IDX_W - 1);
            r_use_mod <= (r_sent >= SENT_LIMIT) || !i_cfg.lite_enabled;
            r_peer_ms <= {7'd0, i_req.peer_count} * {10'd0, PEER_PERIOD_MS};
        end
        if (i_cmd.prep) begin
            r_ceil <= ({3'd0, r_peer_ms} < i_cfg.max_period_ms) ?
                      i_cfg.max_period_ms : {3'd0, r_peer_ms};
            r_grow <= w_times9[23:3];
        end
        if (i_cmd.step) begin
            r_rem  <= (w_rem_sh >= r_div) ? w_rem_sub[IDX_W-1:0] : w_rem_sh[IDX_W-1:0];
            r_step <= r_step - 1'b1;
        end
    end

    // Scheduler state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= IDX_W'(PORT_COUNT - 1);
            r_sent      <= '0;
            r_period    <= INIT_PERIOD_MS;
            r_remote_en <= '1;
        end else begin
            if (i_cmd.clear_fail) begin
                r_remote_en[i_req.failed_port[IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_cur    <= w_fin_idx;
                r_period <= w_new_period;
                if (r_sent < SENT_LIMIT) begin
                    r_sent <= r_sent + 1'b1;
                end
            end
        end
    end

    // Output register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.port_index    <= 4'(w_fin_idx);
            r_out.port_number   <= port_of(w_fin_idx);
            r_out.send_local    <= (w_fin_idx != w_own);
            r_out.send_remote   <= i_cfg.network_present && r_remote_en[w_fin_idx];
            r_out.next_delay_ms <= w_new_period;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> ({1'b0, r_rem} < r_div))
        else $error("division remainder not below divisor");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period >= MIN_PERIOD_MS) && (r_period <= MAX_PERIOD_LIMIT))
        else $error("beacon period out of range");

    a_sent_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_sent == SENT_LIMIT) |=> (r_sent == SENT_LIMIT))
        else $error("beacon count left saturation");

endmodule
`default_nettype wire
